FILE: hdl/obb_pkg.sv
// Package with widths shared by the box overlap test.
`timescale 1ns / 1ps
`default_nettype none
package obb_pkg;
  localparam int FIELD_W = 63;
  localparam int BIAS_W  = 10;
endpackage
`default_nettype wire

FILE: hdl/obb_if.sv
// Handshake channel interfaces for the box overlap test.
`timescale 1ns / 1ps
`default_nettype none
interface obb_in_if;
  logic        valid;
  logic        ready;
  logic [62:0] a_axis_x, a_axis_y, a_axis_z, b_axis_x, b_axis_y, b_axis_z;
  logic [62:0] a_center, b_center, a_scale, a_size, b_scale, b_size;
  modport source (output valid, a_axis_x, a_axis_y, a_axis_z, b_axis_x, b_axis_y,
                  b_axis_z, a_center, b_center, a_scale, a_size, b_scale, b_size,
                  input ready);
  modport sink (input valid, a_axis_x, a_axis_y, a_axis_z, b_axis_x, b_axis_y,
                b_axis_z, a_center, b_center, a_scale, a_size, b_scale, b_size,
                output ready);
endinterface

interface obb_out_if;
  logic valid;
  logic ready;
  logic overlap;
  modport source (output valid, overlap, input ready);
  modport sink (input valid, overlap, output ready);
endinterface

interface obb_cfg_if;
  logic       valid;
  logic       ready;
  logic [9:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

FILE: hdl/obb_front.sv
// Front stages: relative rotation, offset in A's frame and half extents.
`timescale 1ns / 1ps
`default_nettype none
module obb_front #(
  parameter int CW = 21,
  parameter int FW = 10
) (
  input  wire logic                 clk,
  input  wire logic                 en,
  input  wire logic [63*12-1:0]     fields,
  output logic signed [CW+1:0]      r_o [9],
  output logic signed [CW+1:0]      t_o [3],
  output logic signed [CW+1:0]      ea_o [3],
  output logic signed [CW+1:0]      eb_o [3]
);
  import obb_pkg::*;
  localparam int PW = 2*CW + 4;
  localparam logic signed [PW-1:0] LIM = PW'((64'sd1 <<< (CW+1)) - 1);

  // Rounding half up with saturation to the symmetric limit.
  function automatic logic signed [CW+1:0] rnd_sat(input logic signed [PW-1:0] x,
                                                  input int s);
    logic signed [PW-1:0] y;
    y = (x + (PW'(1) <<< (s-1))) >>> s;
    if (y > LIM) return LIM[CW+1:0];
    if (y < -LIM) return -LIM[CW+1:0];
    return y[CW+1:0];
  endfunction

  // Stage 1: component products.
  logic signed [PW-1:0] pr_r [9][3];
  logic signed [PW-1:0] pt_r [3][3];
  logic signed [PW-1:0] pa_r [3], pb_r [3];
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        for (int k = 0; k < 3; k++) begin
          for (int j = 0; j < 3; j++) begin
            pr_r[i*3+j][k] <= PW'($signed(fields[i*63+k*CW +: CW]))
                            * PW'($signed(fields[(3+j)*63+k*CW +: CW]));
          end
          pt_r[i][k] <= (PW'($signed(fields[7*63+k*CW +: CW]))
                       - PW'($signed(fields[6*63+k*CW +: CW])))
                       * PW'($signed(fields[i*63+k*CW +: CW]));
        end
        pa_r[i] <= PW'($signed(fields[8*63+i*CW +: CW]))
                 * PW'($signed(fields[9*63+i*CW +: CW]));
        pb_r[i] <= PW'($signed(fields[10*63+i*CW +: CW]))
                 * PW'($signed(fields[11*63+i*CW +: CW]));
      end
    end
  end

  // Stage 2: sums, rounding and saturation.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int n = 0; n < 9; n++) r_o[n] <= rnd_sat(pr_r[n][0]+pr_r[n][1]+pr_r[n][2], FW);
      for (int i = 0; i < 3; i++) begin
        t_o[i]  <= rnd_sat(pt_r[i][0]+pt_r[i][1]+pt_r[i][2], FW);
        ea_o[i] <= rnd_sat(pa_r[i], FW+1);
        eb_o[i] <= rnd_sat(pb_r[i], FW+1);
      end
    end
  end
endmodule
`default_nettype wire

FILE: hdl/obb_axes.sv
// Back stages: fifteen axis projections and the final separation decision.
`timescale 1ns / 1ps
`default_nettype none
module obb_axes #(
  parameter int CW = 21,
  parameter int FW = 10
) (
  input  wire logic                clk,
  input  wire logic                en,
  input  wire logic [9:0]          bias,
  input  wire logic signed [CW+1:0] r_i [9],
  input  wire logic signed [CW+1:0] t_i [3],
  input  wire logic signed [CW+1:0] ea_i [3],
  input  wire logic signed [CW+1:0] eb_i [3],
  output logic                     overlap_o
);
  import obb_pkg::*;
  localparam int QW = 2*CW + 10;

  // Stage 3: absolute rotation terms with bias, copies of the rest.
  logic signed [CW+3:0] ar_r [9];
  logic signed [CW+1:0] r_r [9], t_r [3], ea_r [3], eb_r [3];
  always_ff @(posedge clk) begin
    if (en) begin
      for (int n = 0; n < 9; n++) begin
        ar_r[n] <= (r_i[n] < 0 ? -(CW+4)'(r_i[n]) : (CW+4)'(r_i[n]))
                 + (CW+4)'($signed({1'b0, bias}));
        r_r[n] <= r_i[n];
      end
      t_r <= t_i; ea_r <= ea_i; eb_r <= eb_i;
    end
  end

  // Stage 4: all products of the fifteen tests.
  logic signed [QW-1:0] m_ra [15][3], m_rb [15][3], m_p [15][3];
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        m_ra[i][0] <= QW'(ea_r[i]) <<< FW; m_ra[i][1] <= '0; m_ra[i][2] <= '0;
        m_p[i][0] <= QW'(t_r[i]) <<< FW; m_p[i][1] <= '0; m_p[i][2] <= '0;
        for (int k = 0; k < 3; k++) begin
          m_rb[i][k] <= QW'(eb_r[k]) * QW'(ar_r[i*3+k]);
          m_ra[3+i][k] <= QW'(ea_r[k]) * QW'(ar_r[k*3+i]);
          m_p[3+i][k] <= QW'(t_r[k]) * QW'(r_r[k*3+i]);
        end
        m_rb[3+i][0] <= QW'(eb_r[i]) <<< FW; m_rb[3+i][1] <= '0; m_rb[3+i][2] <= '0;
        for (int j = 0; j < 3; j++) begin
          m_ra[6+i*3+j][0] <= QW'(ea_r[(i+1)%3]) * QW'(ar_r[((i+2)%3)*3+j]);
          m_ra[6+i*3+j][1] <= QW'(ea_r[(i+2)%3]) * QW'(ar_r[((i+1)%3)*3+j]);
          m_ra[6+i*3+j][2] <= '0;
          m_rb[6+i*3+j][0] <= QW'(eb_r[(j+1)%3]) * QW'(ar_r[i*3+(j+2)%3]);
          m_rb[6+i*3+j][1] <= QW'(eb_r[(j+2)%3]) * QW'(ar_r[i*3+(j+1)%3]);
          m_rb[6+i*3+j][2] <= '0;
          m_p[6+i*3+j][0] <= QW'(t_r[(i+2)%3]) * QW'(r_r[((i+1)%3)*3+j]);
          m_p[6+i*3+j][1] <= -(QW'(t_r[(i+1)%3]) * QW'(r_r[((i+2)%3)*3+j]));
          m_p[6+i*3+j][2] <= '0;
        end
      end
    end
  end

  // Stage 5: sums and compares.
  logic [14:0] sep_r;
  always_ff @(posedge clk) begin
    if (en) begin
      for (int a = 0; a < 15; a++) begin
        logic signed [QW-1:0] p, rr;
        p  = m_p[a][0] + m_p[a][1] + m_p[a][2];
        rr = m_ra[a][0] + m_ra[a][1] + m_ra[a][2] + m_rb[a][0] + m_rb[a][1] + m_rb[a][2];
        sep_r[a] <= ((p < 0) ? -p : p) > rr;
      end
    end
  end
  assign overlap_o = ~|sep_r;
endmodule
`default_nettype wire

FILE: hdl/obb_obb_overlap_test.sv
// Top level of the oriented box overlap test (fifteen separating axes).
// Throughput: one item per cycle; the six-stage pipeline stalls as a whole.
// Output is a registered stage; reset clears valid bits, bias_r resets to 1.
`timescale 1ns / 1ps
`default_nettype none
module obb_obb_overlap_test #(
  parameter int COMPONENT_BITS = 21,
  parameter int FRACTION_BITS  = 10
) (
  input wire logic clk,
  input wire logic rst_n,
  obb_in_if.sink   in_ch,
  obb_out_if.source out_ch,
  obb_cfg_if.sink  cfg_ch
);
  import obb_pkg::*;
  localparam int DEPTH = 6;

  logic [BIAS_W-1:0] bias_r;
  logic [DEPTH-1:0]  vld_r;
  logic              en;
  logic              ovl_r;
  logic              res;

  // Configuration register.
  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bias_r <= BIAS_W'(1);
    end else if (cfg_ch.valid) begin
      bias_r <= cfg_ch.data;
    end
  end

  // The whole pipeline advances unless the last item is held.
  assign en = !(vld_r[DEPTH-1] && !out_ch.ready);
  assign in_ch.ready = en;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[DEPTH-2:0], in_ch.valid};
    end
  end

  logic [63*12-1:0] fields;
  assign fields = {in_ch.b_size, in_ch.b_scale, in_ch.a_size, in_ch.a_scale,
                   in_ch.b_center, in_ch.a_center, in_ch.b_axis_z, in_ch.b_axis_y,
                   in_ch.b_axis_x, in_ch.a_axis_z, in_ch.a_axis_y, in_ch.a_axis_x};

  logic signed [COMPONENT_BITS+1:0] r [9], t [3], ea [3], eb [3];
  obb_front #(.CW(COMPONENT_BITS), .FW(FRACTION_BITS)) u_front (
    .clk, .en, .fields, .r_o(r), .t_o(t), .ea_o(ea), .eb_o(eb));
  obb_axes #(.CW(COMPONENT_BITS), .FW(FRACTION_BITS)) u_axes (
    .clk, .en, .bias(bias_r), .r_i(r), .t_i(t), .ea_i(ea), .eb_i(eb),
    .overlap_o(res));

  // Output register.
  always_ff @(posedge clk) begin
    if (en) ovl_r <= res;
  end
  assign out_ch.valid   = vld_r[DEPTH-1];
  assign out_ch.overlap = ovl_r;

  // A held result stays put.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.overlap))
    else $error("held result changed");
  // Input is refused exactly when the output stalls.
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready == !(out_ch.valid && !out_ch.ready))
    else $error("stall mismatch");
endmodule
`default_nettype wire
